### src/rotate_project_zbuffer_plot_defines.svh
// Assertion helpers used by the assertion checker in src/rpz_checker.sv.
// Both expect clk and rst_n in the scope of use.
`ifndef ROTATE_PROJECT_ZBUFFER_PLOT_DEFINES_SVH
`define ROTATE_PROJECT_ZBUFFER_PLOT_DEFINES_SVH

// Same-cycle implication
`define RPZ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpz assertion failed");

// Next-cycle implication
`define RPZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpz assertion failed");

`endif

### src/rpz_pkg.sv
package rpz_pkg;

  localparam int CELL_W    = 16;
  localparam int QDEPTH    = 2;
  localparam int DIV_W     = 60;
  localparam int DIVISOR_W = 44;
  localparam int QUO_W     = 16;
  localparam int STEP_W    = 5;

  localparam logic [7:0]  CHAR_SPACE = 8'd32;
  localparam logic [15:0] DEPTH_SAT  = 16'hFFFF;
  localparam logic [3:0]  LUM_MAX    = 4'd10;

  localparam logic signed [15:0] RST_SIN   = 16'sd0;
  localparam logic signed [15:0] RST_COS   = 16'sd16384;
  localparam logic [15:0]        RST_VIEW  = 16'd2560;
  localparam logic [15:0]        RST_SCALE = 16'd3413;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PLOT  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SIN_A      = 3'd0,
    REG_COS_A      = 3'd1,
    REG_SIN_B      = 3'd2,
    REG_COS_B      = 3'd3,
    REG_VIEW_DIST  = 3'd4,
    REG_PROJ_SCALE = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PLOT,
    OP_READ,
    OP_FIXED
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] addr;
    logic [15:0]       depth;
    logic [7:0]        ch;
  } qentry_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [15:0] cell_depth;
    logic        written;
  } result_t;

  typedef struct packed {
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_b;
    logic signed [15:0] cos_b;
    logic [15:0]        view_distance;
    logic [15:0]        projection_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_MUL3,
    F_ROT,
    F_PROJ1,
    F_PROJ2,
    F_CHECK,
    F_DEPTH,
    F_DIVX,
    F_DIVY,
    F_CELL,
    F_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOK,
    B_REPLY
  } be_state_t;

  // Shade ramp, darkest to brightest
  function automatic logic [7:0] shade(input logic [3:0] li);
    logic [7:0] c;
    unique case (li)
      4'd0:    c = 8'd46;   // .
      4'd1:    c = 8'd44;   // ,
      4'd2:    c = 8'd45;   // -
      4'd3:    c = 8'd126;  // ~
      4'd4:    c = 8'd58;   // :
      4'd5:    c = 8'd59;   // ;
      4'd6:    c = 8'd33;   // !
      4'd7:    c = 8'd42;   // *
      4'd8:    c = 8'd35;   // #
      4'd9:    c = 8'd36;   // $
      default: c = 8'd64;   // @
    endcase
    return c;
  endfunction

endpackage

### src/rpz_in_if.sv
interface rpz_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic signed [1:0]  normal_x;
  logic signed [1:0]  normal_y;
  logic signed [1:0]  normal_z;
  logic [12:0]        cell_index;

  modport source (output valid, kind, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, cell_index, input ready);
  modport sink (input valid, kind, point_x, point_y, point_z,
                normal_x, normal_y, normal_z, cell_index, output ready);
endinterface

### src/rpz_out_if.sv
interface rpz_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [15:0] cell_depth;
  logic        written;

  modport source (output valid, cell_char, cell_depth, written, input ready);
  modport sink (input valid, cell_char, cell_depth, written, output ready);
endinterface

### src/rpz_cfg_if.sv
interface rpz_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/rpz_div.sv
module rpz_div import rpz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  input  logic [STEP_W-1:0]    steps,
  output logic                 done,
  output logic [QUO_W-1:0]     quotient
);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  assign fits = rem_r >= den_r;

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      den_r <= DIV_W'(divisor) << (steps - STEP_W'(1));
      quo_r <= '0;
      cnt_r <= steps;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], fits};
      den_r <= den_r >> 1;
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/rpz_front.sv
module rpz_front import rpz_pkg::*; #(
  parameter int SCREEN_COLS = 128,
  parameter int SCREEN_ROWS = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    init_done,
  input  cfg_t    cfg,
  rpz_in_if.sink  in_ch,
  output qentry_t q_entry,
  output logic    q_push,
  input  logic    q_full
);

  localparam int CELLS     = SCREEN_COLS * SCREEN_ROWS;
  localparam int QB        = $clog2((SCREEN_COLS > SCREEN_ROWS) ? SCREEN_COLS : SCREEN_ROWS);
  localparam int HALF_COLS = SCREEN_COLS / 2;
  localparam int HALF_ROWS = SCREEN_ROWS / 2;

  fe_state_t state_r, state_nxt;

  logic signed [15:0] px_r, py_r, pz_r;
  logic signed [1:0]  nx_r, ny_r, nz_r;
  logic signed [31:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [32:0] t_r, x26_r;
  logic signed [48:0] st_r, ct_r;
  logic signed [35:0] y26_r;
  logic signed [36:0] z26_r;
  logic [35:0]        zu;
  logic signed [49:0] a_r;
  logic signed [52:0] b_r;
  logic [39:0]        d16_r;
  logic [42:0]        d80_r;
  logic signed [55:0] numx_r, numy_r;
  logic [55:0]        colsden_r, rowsden_r;
  logic signed [18:0] tn_r, nd_r;
  logic signed [35:0] lp_r;
  logic signed [37:0] lum;
  logic [12:0]        lq;
  logic [3:0]         li_r, li_nxt;
  logic [15:0]        depth_r;
  logic [QB-1:0]      sx_r, sy_r;
  qentry_t            entry_r;

  logic               in_ready, take;
  logic               in_view, depth_sat, idx_ok;
  logic signed [56:0] gx, gy;
  logic [DIV_W-1:0]   x_dividend, y_dividend;

  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [STEP_W-1:0]    div_steps;
  logic [QUO_W-1:0]     div_quo;

  assign in_ready    = (state_r == F_IDLE) && init_done;
  assign in_ch.ready = in_ready;
  assign take        = in_ch.valid && in_ready;
  assign idx_ok      = 17'(in_ch.cell_index) < 17'(CELLS);

  // Screen and depth tests on the settled projection terms
  assign zu        = z26_r[35:0];
  assign gx        = 57'(numx_r) + 57'($signed({1'b0, d16_r}));
  assign gy        = 57'(numy_r) + 57'($signed({1'b0, d80_r}));
  assign in_view   = (z26_r > 37'sd0) && (gx > 57'sd0) && (gy > 57'sd0) &&
                     (numx_r < $signed({1'b0, colsden_r})) &&
                     (numy_r < $signed({1'b0, rowsden_r}));
  assign depth_sat = zu <= 36'(64'd1 << 26);

  assign x_dividend = numx_r[55] ? '0 : DIV_W'(numx_r[54:0]);
  assign y_dividend = numy_r[55] ? '0 : DIV_W'(numy_r[54:0]);

  // Luminance index from the rotated normal
  assign lum    = (38'(nd_r) <<< 14) - 38'(lp_r);
  assign lq     = lum[37:25];
  assign li_nxt = (lum <= 38'sd0) ? 4'd0 : ((lq > 13'(LUM_MAX)) ? LUM_MAX : lq[3:0]);

  rpz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the item and hand operands to the divider
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    unique case (state_r)
      F_IDLE: begin
        if (take) begin
          state_nxt = (kind_t'(in_ch.kind) == KIND_PLOT) ? F_MUL1 : F_PUSH;
        end
      end
      F_MUL1:  state_nxt = F_MUL2;
      F_MUL2:  state_nxt = F_MUL3;
      F_MUL3:  state_nxt = F_ROT;
      F_ROT:   state_nxt = F_PROJ1;
      F_PROJ1: state_nxt = F_PROJ2;
      F_PROJ2: state_nxt = F_CHECK;
      F_CHECK: begin
        if (!in_view) begin
          state_nxt = F_PUSH;
        end else if (depth_sat) begin
          div_start    = 1'b1;
          div_dividend = x_dividend;
          div_divisor  = DIVISOR_W'(d16_r);
          div_steps    = STEP_W'(QB);
          state_nxt    = F_DIVX;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(64'd1 << 42);
          div_divisor  = DIVISOR_W'(zu);
          div_steps    = STEP_W'(QUO_W);
          state_nxt    = F_DEPTH;
        end
      end
      F_DEPTH: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = x_dividend;
          div_divisor  = DIVISOR_W'(d16_r);
          div_steps    = STEP_W'(QB);
          state_nxt    = F_DIVX;
        end
      end
      F_DIVX: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = y_dividend;
          div_divisor  = DIVISOR_W'(d80_r);
          div_steps    = STEP_W'(QB);
          state_nxt    = F_DIVY;
        end
      end
      F_DIVY: begin
        if (div_done) begin
          state_nxt = F_CELL;
        end
      end
      F_CELL: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Rotation and projection chain, one product level per register
  always_ff @(posedge clk) begin
    p1_r <= pz_r * $signed(cfg.cos_b);
    p2_r <= px_r * $signed(cfg.sin_b);
    p3_r <= px_r * $signed(cfg.cos_b);
    p4_r <= pz_r * $signed(cfg.sin_b);
    p5_r <= py_r * $signed(cfg.cos_a);
    p6_r <= py_r * $signed(cfg.sin_a);

    t_r   <= 33'(p1_r) - 33'(p2_r);
    x26_r <= 33'(p3_r) + 33'(p4_r);

    st_r <= $signed(cfg.sin_a) * t_r;
    ct_r <= $signed(cfg.cos_a) * t_r;

    y26_r <= 36'(p5_r) - 36'(st_r >>> 14);
    z26_r <= 37'($signed({1'b0, cfg.view_distance, 18'd0})) + 37'(p6_r) + 37'(ct_r >>> 14);

    a_r   <= $signed({1'b0, cfg.projection_scale}) * x26_r;
    b_r   <= $signed({1'b0, cfg.projection_scale}) * y26_r;
    d16_r <= {zu, 4'd0};
    d80_r <= 43'({zu, 6'd0}) + 43'({zu, 4'd0});

    numx_r    <= $signed(56'(d16_r) * 56'(HALF_COLS)) + 56'(a_r);
    numy_r    <= $signed(56'(d80_r) * 56'(HALF_ROWS)) - (56'(b_r) <<< 1);
    colsden_r <= 56'(d16_r) * 56'(SCREEN_COLS);
    rowsden_r <= 56'(d80_r) * 56'(SCREEN_ROWS);

    tn_r <= nz_r * $signed(cfg.cos_b) - nx_r * $signed(cfg.sin_b);
    nd_r <= ny_r * ($signed(cfg.cos_a) - $signed(cfg.sin_a));
    lp_r <= ($signed(cfg.sin_a) + $signed(cfg.cos_a)) * tn_r;
    li_r <= li_nxt;
  end

  // Capture the item, then collect divider results into the queue entry
  always_ff @(posedge clk) begin
    if (take) begin
      px_r <= in_ch.point_x;
      py_r <= in_ch.point_y;
      pz_r <= in_ch.point_z;
      nx_r <= in_ch.normal_x;
      ny_r <= in_ch.normal_y;
      nz_r <= in_ch.normal_z;
      entry_r.addr  <= CELL_W'(in_ch.cell_index);
      entry_r.depth <= '0;
      entry_r.ch    <= (kind_t'(in_ch.kind) == KIND_READ && !idx_ok) ? CHAR_SPACE : 8'd0;
      unique case (kind_t'(in_ch.kind))
        KIND_CLEAR: entry_r.op <= OP_CLEAR;
        KIND_PLOT:  entry_r.op <= OP_PLOT;
        KIND_READ:  entry_r.op <= idx_ok ? OP_READ : OP_FIXED;
        default:    entry_r.op <= OP_FIXED;
      endcase
    end
    if (state_r == F_CHECK) begin
      if (!in_view) begin
        entry_r.op    <= OP_FIXED;
        entry_r.depth <= '0;
        entry_r.ch    <= '0;
      end
      if (depth_sat) begin
        depth_r <= DEPTH_SAT;
      end
    end
    if (state_r == F_DEPTH && div_done) begin
      depth_r <= div_quo;
    end
    if (state_r == F_DIVX && div_done) begin
      sx_r <= div_quo[QB-1:0];
    end
    if (state_r == F_DIVY && div_done) begin
      sy_r <= div_quo[QB-1:0];
    end
    if (state_r == F_CELL) begin
      entry_r.op    <= OP_PLOT;
      entry_r.addr  <= CELL_W'(sx_r) + CELL_W'(sy_r) * CELL_W'(SCREEN_COLS);
      entry_r.depth <= depth_r;
      entry_r.ch    <= shade(li_r);
    end
  end

  assign q_entry = entry_r;
  assign q_push  = (state_r == F_PUSH) && !q_full;

endmodule

### src/rpz_fifo.sv
module rpz_fifo import rpz_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    full,
  input  logic    pop,
  output qentry_t pop_entry,
  output logic    nonempty
);

  localparam int PW = $clog2(QDEPTH);

  qentry_t         slot_r [QDEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [PW:0]     count_r;

  assign full      = count_r == (PW+1)'(QDEPTH);
  assign nonempty  = count_r != '0;
  assign pop_entry = slot_r[rptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

endmodule

### src/rpz_back.sv
module rpz_back import rpz_pkg::*; #(
  parameter int SCREEN_COLS = 128,
  parameter int SCREEN_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  qentry_t     q_entry,
  output logic        q_pop,
  output logic        init_done,
  rpz_out_if.source   out_ch
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);

  be_state_t state_r, state_nxt;

  logic [15:0]   depth_mem [CELLS];
  logic [7:0]    char_mem  [CELLS];
  logic [15:0]   rd_depth_r;
  logic [7:0]    rd_char_r;
  logic [AW-1:0] clr_addr_r;
  logic          booted_r;
  qentry_t       cur_r;
  result_t       pend_r;
  result_t       out_r;
  logic          out_valid_r;
  logic          out_free;
  logic          clr_last;
  logic          hit;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdepth;
  logic [7:0]    wchar;

  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = clr_addr_r == AW'(CELLS - 1);
  assign hit      = cur_r.depth > rd_depth_r;
  assign q_pop    = (state_r == B_IDLE) && q_nonempty;
  assign init_done = booted_r;

  // Write port: clearing sweep or depth-test win
  always_comb begin
    we     = 1'b0;
    waddr  = clr_addr_r;
    wdepth = '0;
    wchar  = CHAR_SPACE;
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        we = 1'b1;
        if (clr_last) begin
          state_nxt = booted_r ? B_REPLY : B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_nonempty) begin
          unique case (q_entry.op)
            OP_CLEAR:          state_nxt = B_CLEAR;
            OP_READ, OP_PLOT:  state_nxt = B_LOOK;
            default:           state_nxt = B_REPLY;
          endcase
        end
      end
      B_LOOK: begin
        if (cur_r.op == OP_PLOT && hit) begin
          we     = 1'b1;
          waddr  = cur_r.addr[AW-1:0];
          wdepth = cur_r.depth;
          wchar  = cur_r.ch;
        end
        state_nxt = B_REPLY;
      end
      B_REPLY: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      depth_mem[waddr] <= wdepth;
      char_mem[waddr]  <= wchar;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_depth_r <= depth_mem[q_entry.addr[AW-1:0]];
      rd_char_r  <= char_mem[q_entry.addr[AW-1:0]];
    end
  end

  // Control: state, sweep address, boot flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      booted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_last) begin
          booted_r <= 1'b1;
        end
      end else begin
        clr_addr_r <= '0;
      end
      if (state_r == B_REPLY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Build the pending result, then move it to the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
      pend_r.cell_char  <= (q_entry.op == OP_CLEAR) ? CHAR_SPACE : q_entry.ch;
      pend_r.cell_depth <= (q_entry.op == OP_CLEAR) ? 16'd0 : q_entry.depth;
      pend_r.written    <= 1'b0;
    end
    if (state_r == B_LOOK) begin
      if (cur_r.op == OP_READ) begin
        pend_r.cell_char  <= rd_char_r;
        pend_r.cell_depth <= rd_depth_r;
        pend_r.written    <= 1'b0;
      end else begin
        pend_r.cell_char  <= hit ? cur_r.ch : 8'd0;
        pend_r.cell_depth <= hit ? cur_r.depth : 16'd0;
        pend_r.written    <= hit;
      end
    end
    if (state_r == B_REPLY && out_free) begin
      out_r <= pend_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_r.cell_char;
  assign out_ch.cell_depth = out_r.cell_depth;
  assign out_ch.written    = out_r.written;

endmodule

### src/rotate_project_zbuffer_plot.sv
// Plots pass the rotation and projection registers, then the shared restoring divider for the
// depth (skipped when the depth saturates), column and row, before the queue push.
// Rejected plots skip the divider; reads, clears and unused kinds go straight to the queue.
// The front end takes one item at a time; the next transfer follows its queue push.
// Reset: synchronous, active low; a sweep over all SCREEN_COLS*SCREEN_ROWS cells then clears the
// screen with in_ch.ready low; configuration writes are taken throughout.
module rotate_project_zbuffer_plot import rpz_pkg::*; #(
  parameter int SCREEN_COLS = 128,
  parameter int SCREEN_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rpz_in_if.sink     in_ch,
  rpz_out_if.source  out_ch,
  rpz_cfg_if.sink    cfg_ch
);

  cfg_t    cfg_r;
  qentry_t push_entry, pop_entry;
  logic    push, pop, full, nonempty, init_done;

  assign cfg_ch.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sin_a            <= RST_SIN;
      cfg_r.cos_a            <= RST_COS;
      cfg_r.sin_b            <= RST_SIN;
      cfg_r.cos_b            <= RST_COS;
      cfg_r.view_distance    <= RST_VIEW;
      cfg_r.projection_scale <= RST_SCALE;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_SIN_A:      cfg_r.sin_a            <= cfg_ch.data;
        REG_COS_A:      cfg_r.cos_a            <= cfg_ch.data;
        REG_SIN_B:      cfg_r.sin_b            <= cfg_ch.data;
        REG_COS_B:      cfg_r.cos_b            <= cfg_ch.data;
        REG_VIEW_DIST:  cfg_r.view_distance    <= cfg_ch.data;
        REG_PROJ_SCALE: cfg_r.projection_scale <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  rpz_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .q_entry   (push_entry),
    .q_push    (push),
    .q_full    (full)
  );

  rpz_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .nonempty   (nonempty)
  );

  rpz_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (nonempty),
    .q_entry    (pop_entry),
    .q_pop      (pop),
    .init_done  (init_done),
    .out_ch     (out_ch)
  );

endmodule

### src/rpz_checker.sv
`include "rotate_project_zbuffer_plot_defines.svh"

module rpz_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  cell_char,
  input logic [15:0] cell_depth,
  input logic        written
);

  // A stalled result stays offered and unchanged
  `RPZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RPZ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(cell_char) && $stable(cell_depth) && $stable(written))

  // A winning plot always carries a real depth and a shade character
  `RPZ_ASSERT_IMP(a_written_payload, out_valid && written, cell_depth != 16'd0 && cell_char != 8'd0 && cell_char != 8'd32)

endmodule

bind rotate_project_zbuffer_plot rpz_sva u_rpz_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cell_char  (out_ch.cell_char),
  .cell_depth (out_ch.cell_depth),
  .written    (out_ch.written)
);

### verif/rpz_checker.sv
module rpz_checker import rpz_pkg::*; #(
  parameter int SCREEN_COLS = 128,
  parameter int SCREEN_ROWS = 64
) (
  input  logic clk,
  input  logic rst_n,
  rpz_in_if    in_mon,
  rpz_out_if   out_mon,
  rpz_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;

  logic [15:0] depth_map [CELLS];
  logic [7:0]  char_map  [CELLS];
  longint      sin_a, cos_a, sin_b, cos_b, view_dist, proj_scale;
  result_t     expected_cells [$];

  // Reset the whole screen to empty
  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) begin
      depth_map[i] = '0;
      char_map[i]  = CHAR_SPACE;
    end
  endfunction

  // Shade character for a luminance index, darkest first
  function automatic logic [7:0] shade_char(input longint li);
    logic [7:0] ramp [11];
    ramp = '{8'd46, 8'd44, 8'd45, 8'd126, 8'd58, 8'd59, 8'd33, 8'd42, 8'd35, 8'd36, 8'd64};
    return ramp[li];
  endfunction

  // Rotate, project and depth-test one point; update the screen on a win
  function automatic result_t rasterize(input logic [15:0] ux, uy, uz,
                                        input logic [1:0] unx, uny, unz);
    result_t r;
    longint  px, py, pz, nx, ny, nz, t, x26, y26, z26, depth, den, col, row, tn, lum, li;
    int      pos;
    r = '0;
    px = longint'($signed(ux));
    py = longint'($signed(uy));
    pz = longint'($signed(uz));
    nx = longint'($signed(unx));
    ny = longint'($signed(uny));
    nz = longint'($signed(unz));
    t   = pz * cos_b - px * sin_b;
    x26 = px * cos_b + pz * sin_b;
    y26 = py * cos_a - ((sin_a * t) >>> 14);
    z26 = view_dist * 262144 + py * sin_a + ((cos_a * t) >>> 14);
    if (z26 <= 0) return r;
    depth = (64'sd1 <<< 42) / z26;
    if (depth > 65535) depth = 65535;
    den = 16 * z26;
    col = (longint'(SCREEN_COLS / 2) * den + proj_scale * x26) / den;
    den = 80 * z26;
    row = (longint'(SCREEN_ROWS / 2) * den - 2 * proj_scale * y26) / den;
    if (col < 0 || col >= SCREEN_COLS || row < 0 || row >= SCREEN_ROWS) return r;
    pos = int'(col + row * SCREEN_COLS);
    if (depth <= longint'(depth_map[pos])) return r;
    tn  = nz * cos_b - nx * sin_b;
    lum = ny * cos_a * 16384 - sin_a * tn - ny * sin_a * 16384 - cos_a * tn;
    li  = lum / (64'sd1 <<< 25);
    if (li < 0) li = 0;
    if (li > 10) li = 10;
    depth_map[pos] = depth[15:0];
    char_map[pos]  = shade_char(li);
    r.cell_char  = char_map[pos];
    r.cell_depth = depth[15:0];
    r.written    = 1'b1;
    return r;
  endfunction

  // Track config, predict each input transfer, compare each output transfer
  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      expected_cells.delete();
      wipe_screen();
      sin_a = 0; cos_a = 16384; sin_b = 0; cos_b = 16384;
      view_dist = 2560; proj_scale = 3413;
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.cell_char, out_mon.cell_depth, out_mon.written};
        if (expected_cells.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", got);
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected char %0d depth %0d written %0d, got %0d %0d %0d",
                       want.cell_char, want.cell_depth, want.written,
                       got.cell_char, got.cell_depth, got.written);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = '0;
        case (kind_t'(in_mon.kind))
          KIND_CLEAR: begin
            wipe_screen();
            want.cell_char = CHAR_SPACE;
          end
          KIND_READ: begin
            if (in_mon.cell_index < CELLS) begin
              want.cell_char  = char_map[in_mon.cell_index];
              want.cell_depth = depth_map[in_mon.cell_index];
            end else begin
              want.cell_char = CHAR_SPACE;
            end
          end
          KIND_PLOT: want = rasterize(in_mon.point_x, in_mon.point_y, in_mon.point_z,
                                      in_mon.normal_x, in_mon.normal_y, in_mon.normal_z);
          default: want = '0;
        endcase
        expected_cells.push_back(want);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_SIN_A:      sin_a = longint'($signed(cfg_mon.data));
          REG_COS_A:      cos_a = longint'($signed(cfg_mon.data));
          REG_SIN_B:      sin_b = longint'($signed(cfg_mon.data));
          REG_COS_B:      cos_b = longint'($signed(cfg_mon.data));
          REG_VIEW_DIST:  view_dist = longint'({48'd0, cfg_mon.data});
          REG_PROJ_SCALE: proj_scale = longint'({48'd0, cfg_mon.data});
          default: ;
        endcase
      end
    end
    pending <= expected_cells.size();
  end
endmodule

### verif/tb_rotate_project_zbuffer_plot.sv
module tb_rotate_project_zbuffer_plot;
  import rpz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, pending, burst_left;
  int   cycles = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  rpz_in_if  in_ch ();
  rpz_out_if out_ch ();
  rpz_cfg_if cfg_ch ();

  rotate_project_zbuffer_plot dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rpz_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side on a changing pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((cycles % 16) < 12);
    endcase
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk iff (cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic set_view(input logic [15:0] sa, ca, sb, cb, vd, ps);
    write_reg(REG_SIN_A, sa);
    write_reg(REG_COS_A, ca);
    write_reg(REG_SIN_B, sb);
    write_reg(REG_COS_B, cb);
    write_reg(REG_VIEW_DIST, vd);
    write_reg(REG_PROJ_SCALE, ps);
    cfg_ch.valid <= 1'b0;
  endtask

  // Transfer one item, opening a new burst after a random gap when due
  task automatic send_item(input kind_t kind, input logic [15:0] px, py, pz,
                           input logic [1:0] nx, ny, nz, input logic [12:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.point_z    <= pz;
    in_ch.normal_x   <= nx;
    in_ch.normal_y   <= ny;
    in_ch.normal_z   <= nz;
    in_ch.cell_index <= idx;
    @(posedge clk iff (in_ch.valid && in_ch.ready));
    burst_left--;
  endtask

  task automatic plot(input logic [15:0] px, py, pz, input logic [1:0] nx, ny, nz);
    send_item(KIND_PLOT, px, py, pz, nx, ny, nz, '0);
  endtask

  // Random axis normal, sometimes the out-of-range minus two code
  function automatic logic [1:0] rand_normal();
    return ($urandom_range(0, 15) == 0) ? 2'b10 : 2'($signed($urandom_range(0, 2) - 1));
  endfunction

  // Point coordinate, mostly near the visible region
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 24576) - 12288));
  endfunction

  task automatic random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 199);
      if (pick < 2)
        send_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      else if (pick < 4)
        send_item(KIND_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), 2'($urandom), 2'($urandom), 13'($urandom));
      else if (pick < 54)
        send_item(KIND_READ, '0, '0, '0, '0, '0, '0,
                  ($urandom_range(0, 3) == 0) ? 13'($urandom)
                                              : 13'($urandom_range(24, 40) * 128
                                                    + $urandom_range(40, 88)));
      else
        plot(rand_coord(), rand_coord(), rand_coord(),
             rand_normal(), rand_normal(), rand_normal());
    end
  endtask

  // Stop sending and let all results drain before touching the registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    burst_left   = 0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_CLEAR;
    in_ch.point_x <= '0; in_ch.point_y <= '0; in_ch.point_z <= '0;
    in_ch.normal_x <= '0; in_ch.normal_y <= '0; in_ch.normal_z <= '0;
    in_ch.cell_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SIN_A;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default view, extremes, repeated point, reads, unused kind and clear
    set_view(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'd2560, 16'd3413);
    send_item(KIND_READ, '0, '0, '0, '0, '0, '0, 13'd4160);
    plot('0, '0, '0, 2'b00, 2'b01, 2'b11);
    plot('0, '0, '0, 2'b00, 2'b01, 2'b11);
    send_item(KIND_READ, '0, '0, '0, '0, '0, '0, 13'd4160);
    plot('0, '0, 16'sh1000, 2'b01, 2'b10, 2'b01);
    plot(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 2'b11, 2'b11, 2'b11);
    plot(16'sh8000, 16'sh8000, 16'sh8000, 2'b10, 2'b10, 2'b10);
    plot(16'sh2000, 16'shE000, 16'shC000, 2'b01, 2'b00, 2'b00);
    plot(16'shE000, 16'sh2000, 16'sh4000, 2'b11, 2'b01, 2'b00);
    send_item(KIND_READ, '0, '0, '0, '0, '0, '0, 13'd0);
    send_item(KIND_READ, '0, '0, '0, '0, '0, '0, 13'h1FFF);
    send_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b11, 2'b11, 2'b11, 13'h1FFF);
    send_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    send_item(KIND_READ, '0, '0, '0, '0, '0, '0, 13'd4160);
    random_items(280);
    drain();

    // Extreme registers
    set_view(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'd65535, 16'd65535);
    plot(16'sh7FFF, 16'sh8000, 16'sh0000, 2'b01, 2'b11, 2'b01);
    random_items(250);
    drain();

    // Nearest view and zero scale: many points fall behind the eye
    set_view(16'sd11585, 16'sd11585, -16'sd6270, 16'sd15137, 16'd256, 16'd0);
    plot(16'sh0000, 16'sh8000, 16'sh8000, 2'b00, 2'b01, 2'b11);
    random_items(250);
    drain();

    // Register values past the unit range
    set_view(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd1024, 16'd1200);
    random_items(250);
    drain();

    // Random angles
    repeat (3) begin
      set_view(16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($urandom_range(1536, 5120)), 16'($urandom_range(1500, 6000)));
      random_items(250);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/rpz_pkg.sv
src/rpz_in_if.sv
src/rpz_out_if.sv
src/rpz_cfg_if.sv
src/rpz_div.sv
src/rpz_front.sv
src/rpz_fifo.sv
src/rpz_back.sv
src/rotate_project_zbuffer_plot.sv
src/rpz_checker.sv
verif/rpz_checker.sv
verif/tb_rotate_project_zbuffer_plot.sv
